// ===== rtl/bfep_pkg.sv =====
// ----------------------------------------------------------------------------
// bfep_pkg
// Shared constants, controller state type and the command/status bundles of
// the bracket frame extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package bfep_pkg;

  localparam int FRAME_BYTES_DEF = 64;

  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  // position of the closing bracket in "[ping]"
  localparam int PING_CLOSE_POS = 5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SEND
  } state_t;

  typedef struct packed {
    logic take;    // input word accepted this cycle
    logic replay;  // start replay of stored frame
    logic notice;  // send a bare pong notice
    logic step;    // advance replay pointer
  } cmd_t;

  typedef struct packed {
    logic frame_done;  // incoming word is a stored closing bracket
    logic pong;        // that frame is "[ping]"
    logic deliver;     // delivery enabled
    logic last;        // output word is the final one
  } status_t;

  function automatic logic [7:0] ping_char(input logic [2:0] k);
    logic [7:0] c;
    unique case (k)
      3'd0:    c = CH_OPEN;
      3'd1:    c = 8'h70;
      3'd2:    c = 8'h69;
      3'd3:    c = 8'h6E;
      3'd4:    c = 8'h67;
      3'd5:    c = CH_CLOSE;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/bracket_frame_extractor_with_ping_core.sv =====
// ----------------------------------------------------------------------------
// bracket_frame_extractor_with_ping_core
// Collects received bytes into bracketed frames and replays completed frames.
// ----------------------------------------------------------------------------
// Input stream (in_*): one received byte per word. CR/LF drop the partial
// frame, '[' restarts it, ']' completes it. A byte arriving with the store at
// FRAME_BYTES-1 entries is dropped and the frame restarts.
// Output stream (out_*): with cfg_wdata=1 written, each completed frame is
// replayed one byte per word, tlast on the final byte; tuser[1] flags a frame
// equal to "[ping]". With delivery off, a "[ping]" frame gives one bare word
// (tuser[0]=0, tdata=0, tlast=1, tuser[1]=1).
// Sequence: a byte that releases no word leaves the block idle, ready for
// another byte. After a closing bracket with delivery on, each result word
// is fetched (frame store read, state FETCH) and then output (state SEND);
// a further word is fetched only after the previous one is taken. A bare
// notice is valid in the cycle after its bracket is taken.
// No input is taken while a frame is being replayed; a stalled receiver holds
// the current word and the whole block.
// Reset (synchronous, rst_n low): frame length cleared, delivery disabled,
// no pending results. Store contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module bracket_frame_extractor_with_ping_core #(
  parameter int FRAME_BYTES = bfep_pkg::FRAME_BYTES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic       cfg_wdata,    // deliver_frames
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,     // [7:0] rx_byte
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,    // [7:0] frame_byte
  output logic            out_tlast,    // frame_last
  output logic [1:0]      out_tuser     // [0] byte_valid, [1] pong_request
);
  import bfep_pkg::*;

  cmd_t    cmd;
  status_t st;
  logic    byte_valid, pong;

  bfep_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .st         (st),
    .cmd        (cmd)
  );

  bfep_datapath #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_byte        (in_tdata),
    .cmd            (cmd),
    .st             (st),
    .out_byte       (out_tdata),
    .out_byte_valid (byte_valid),
    .out_last       (out_tlast),
    .out_pong       (pong)
  );

  assign out_tuser = {pong, byte_valid};

endmodule

`default_nettype wire

// ===== rtl/bfep_datapath.sv =====
// ----------------------------------------------------------------------------
// bfep_datapath
// Frame store, length and ping tracking, replay pointer and result word.
// ----------------------------------------------------------------------------
`default_nettype none

module bfep_datapath #(
  parameter int FRAME_BYTES = 64
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_we,
  input  wire logic            cfg_wdata,
  input  wire logic [7:0]      in_byte,
  input  wire bfep_pkg::cmd_t  cmd,
  output bfep_pkg::status_t    st,
  output logic [7:0]           out_byte,
  output logic                 out_byte_valid,
  output logic                 out_last,
  output logic                 out_pong
);
  import bfep_pkg::*;

  localparam int LEN_W = $clog2(FRAME_BYTES);
  localparam logic [LEN_W-1:0] LIMIT     = LEN_W'(FRAME_BYTES - 1);
  localparam logic [LEN_W-1:0] CLOSE_POS = LEN_W'(PING_CLOSE_POS);

  logic [7:0]       mem [FRAME_BYTES];
  logic [7:0]       rd_data_r;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [LEN_W-1:0] last_idx_r;
  logic             ok_r, ok_nxt;
  logic             pong_r;
  logic             notice_r, notice_nxt;
  logic             deliver_r;

  logic             is_line, is_open, is_close, room, store_en, close_hit, pong_now, char_ok;
  logic [LEN_W-1:0] wr_idx;

  assign is_line   = (in_byte == CH_CR) || (in_byte == CH_LF);
  assign is_open   = (in_byte == CH_OPEN);
  assign is_close  = (in_byte == CH_CLOSE);
  assign room      = (len_r < LIMIT);
  assign wr_idx    = is_open ? '0 : len_r;
  assign store_en  = cmd.take & ~is_line & room;
  assign close_hit = ~is_line & room & is_close;
  // ok_r covers the first five bytes; the bracket here completes the match
  assign pong_now  = close_hit & (wr_idx == CLOSE_POS) & ok_r;
  assign char_ok   = (in_byte == ping_char(wr_idx[2:0]));

  always_comb begin
    len_nxt = len_r;
    ok_nxt  = ok_r;
    if (cmd.take) begin
      if (is_line || !room || is_close) begin
        len_nxt = '0;
      end else begin
        len_nxt = wr_idx + LEN_W'(1);
      end
    end
    if (store_en) begin
      if (wr_idx == '0) begin
        ok_nxt = char_ok;
      end else if (wr_idx < CLOSE_POS) begin
        ok_nxt = ok_r & char_ok;
      end
    end
  end

  always_comb begin
    rd_idx_nxt = rd_idx_r;
    notice_nxt = notice_r;
    if (cmd.replay) begin
      rd_idx_nxt = '0;
      notice_nxt = 1'b0;
    end else if (cmd.notice) begin
      notice_nxt = 1'b1;
    end else if (cmd.step) begin
      rd_idx_nxt = rd_idx_r + LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r     <= '0;
      ok_r      <= 1'b0;
      notice_r  <= 1'b0;
      deliver_r <= 1'b0;
      rd_idx_r  <= '0;
    end else begin
      len_r    <= len_nxt;
      ok_r     <= ok_nxt;
      notice_r <= notice_nxt;
      rd_idx_r <= rd_idx_nxt;
      if (cfg_we) begin
        deliver_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && close_hit) begin
      last_idx_r <= wr_idx;
      pong_r     <= pong_now;
    end
  end

  always_ff @(posedge clk) begin
    if (store_en) begin
      mem[wr_idx] <= in_byte;
    end
    rd_data_r <= mem[rd_idx_r];
  end

  assign st.frame_done = close_hit;
  assign st.pong       = pong_now;
  assign st.deliver    = deliver_r;
  assign st.last       = notice_r | (rd_idx_r == last_idx_r);

  assign out_byte       = notice_r ? 8'h00 : rd_data_r;
  assign out_byte_valid = ~notice_r;
  assign out_last       = st.last;
  assign out_pong       = st.last & pong_r;

endmodule

`default_nettype wire

// ===== rtl/bfep_ctrl.sv =====
// ----------------------------------------------------------------------------
// bfep_ctrl
// Controller: takes input words while idle, then sequences frame replay or a bare pong notice.
// ----------------------------------------------------------------------------
`default_nettype none

module bfep_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  input  wire bfep_pkg::status_t  st,
  output bfep_pkg::cmd_t          cmd
);
  import bfep_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid && st.frame_done) begin
          if (st.deliver) begin
            state_nxt = ST_FETCH;
          end else if (st.pong) begin
            state_nxt = ST_SEND;
          end
        end
      end
      ST_FETCH: state_nxt = ST_SEND;
      ST_SEND: begin
        if (out_tready) begin
          state_nxt = st.last ? ST_IDLE : ST_FETCH;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    cmd        = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.take   = in_tvalid;
        cmd.replay = in_tvalid & st.frame_done & st.deliver;
        cmd.notice = in_tvalid & st.frame_done & ~st.deliver & st.pong;
      end
      ST_FETCH: ;
      ST_SEND: begin
        out_tvalid = 1'b1;
        cmd.step   = out_tready & ~st.last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bfep_checker.sv =====
// ----------------------------------------------------------------------------
// bfep_checker
// Port-level checks of the frame extractor, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bfep_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tready,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic       out_tlast,
  input wire logic [1:0] out_tuser
);

  // input is never taken while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while output valid");

  // pong flag only on the final word of a frame
  a_pong_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tlast)
    else $error("pong flag on non-final word");

  // a bare notice is always a final pong word with zero data
  a_notice: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tlast && out_tuser[1] && (out_tdata == 8'h00))
    else $error("malformed bare notice");

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast)
      && $stable(out_tuser))
    else $error("output word changed while stalled");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind bracket_frame_extractor_with_ping_core bfep_checker u_bfep_checker (.*);

`default_nettype wire

// ===== tb/bracket_frame_extractor_with_ping_core_tb.sv =====
// ----------------------------------------------------------------------------
// bracket_frame_extractor_with_ping_core_tb
// Self-checking bench for the bracket frame extractor. Bytes go in on the
// input stream and a behavioral predictor builds the frames alongside the
// DUT. Every output word is checked against the oldest predicted word. The
// bench starts with a directed table, then runs random frames, pings, broken
// frames and noise with delivery switched on and off. Both streams idle at
// random.
// ----------------------------------------------------------------------------
`default_nettype none

module bracket_frame_extractor_with_ping_core_tb;

  import bfep_pkg::*;

  localparam int FRAME_BYTES = FRAME_BYTES_DEF;
  localparam int RANDOM_WORDS = 125;
  localparam int PHASE_WORDS = 8;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [47:0] PING_TEXT = "[ping]";

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
    logic       pong;
  } word_t;

  typedef enum logic [1:0] {CFG_KEEP, CFG_OFF, CFG_ON} cfg_act_t;
  typedef enum logic [1:0] {CHK_PREDICT, CHK_NONE, CHK_ONE} chk_t;

  typedef struct packed {
    cfg_act_t   act;
    logic [7:0] rx;
    chk_t       chk;
    word_t      typed;
  } dir_row_t;

  localparam word_t NO_WORD     = '0;
  localparam word_t PONG_NOTICE = '{data: 8'h00, valid: 1'b0, last: 1'b1, pong: 1'b1};
  localparam word_t LONE_CLOSE  = '{data: CH_CLOSE, valid: 1'b1, last: 1'b1, pong: 1'b0};

  localparam int DIR_ROWS = 25;

  dir_row_t directed_rows [0:DIR_ROWS-1] = '{
    // delivery off after reset: "[ping]" gives a bare notice
    '{CFG_KEEP, CH_OPEN,  CHK_NONE,    NO_WORD},
    '{CFG_KEEP, 8'h70,    CHK_NONE,    NO_WORD},
    '{CFG_KEEP, 8'h69,    CHK_NONE,    NO_WORD},
    '{CFG_KEEP, 8'h6E,    CHK_NONE,    NO_WORD},
    '{CFG_KEEP, 8'h67,    CHK_NONE,    NO_WORD},
    '{CFG_KEEP, CH_CLOSE, CHK_ONE,     PONG_NOTICE},
    '{CFG_KEEP, CH_CLOSE, CHK_NONE,    NO_WORD},
    // delivery on: frame with no opening bracket, byte extremes
    '{CFG_ON,   8'h00,    CHK_PREDICT, NO_WORD},
    '{CFG_KEEP, 8'hFF,    CHK_PREDICT, NO_WORD},
    '{CFG_KEEP, CH_CLOSE, CHK_PREDICT, NO_WORD},
    // CR drops the partial frame, so ']' comes out alone
    '{CFG_KEEP, CH_OPEN,  CHK_NONE,    NO_WORD},
    '{CFG_KEEP, 8'h70,    CHK_NONE,    NO_WORD},
    '{CFG_KEEP, CH_CR,    CHK_NONE,    NO_WORD},
    '{CFG_KEEP, CH_CLOSE, CHK_ONE,     LONE_CLOSE},
    '{CFG_KEEP, CH_OPEN,  CHK_NONE,    NO_WORD},
    '{CFG_KEEP, 8'h70,    CHK_NONE,    NO_WORD},
    '{CFG_KEEP, 8'h69,    CHK_NONE,    NO_WORD},
    '{CFG_KEEP, 8'h6E,    CHK_NONE,    NO_WORD},
    '{CFG_KEEP, 8'h67,    CHK_NONE,    NO_WORD},
    '{CFG_KEEP, CH_CLOSE, CHK_PREDICT, NO_WORD},
    '{CFG_KEEP, 8'h78,    CHK_NONE,    NO_WORD},
    '{CFG_KEEP, CH_LF,    CHK_NONE,    NO_WORD},
    // delivery off, ordinary frame: silent
    '{CFG_OFF,  CH_OPEN,  CHK_NONE,    NO_WORD},
    '{CFG_KEEP, 8'h7F,    CHK_NONE,    NO_WORD},
    '{CFG_KEEP, CH_CLOSE, CHK_NONE,    NO_WORD}
  };

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_wdata;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic [1:0] out_tuser;

  // predictor state
  logic [7:0] frame_buf [0:FRAME_BYTES-1];
  int         frame_len;
  logic       deliver_on;
  word_t      pending_words [$];

  int errors;
  int rx_taken;
  int tx_mode;
  int tx_left;

  bracket_frame_extractor_with_ping_core #(
    .FRAME_BYTES(FRAME_BYTES)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  always #6 clk = ~clk;

  // Updates the frame state for one received byte and queues the words
  // that byte releases.
  function automatic void absorb_rx_byte(input logic [7:0] b);
    int  n;
    bit  pong;
    if (b == CH_CR || b == CH_LF) begin
      frame_len = 0;
      return;
    end
    // store full: byte dropped, frame restarts
    if (frame_len >= FRAME_BYTES - 1) begin
      frame_len = 0;
      return;
    end
    if (b == CH_OPEN) frame_len = 0;
    frame_buf[frame_len] = b;
    frame_len++;
    if (b != CH_CLOSE) return;
    n = frame_len;
    frame_len = 0;
    pong = (n == 6);
    for (int k = 0; k < 6 && pong; k++) begin
      if (frame_buf[k] != PING_TEXT[8*(5-k) +: 8]) pong = 1'b0;
    end
    if (deliver_on) begin
      for (int k = 0; k < n; k++) begin
        pending_words.push_back('{data: frame_buf[k], valid: 1'b1,
                                  last: (k == n - 1), pong: (k == n - 1) && pong});
      end
    end else if (pong) begin
      pending_words.push_back(PONG_NOTICE);
    end
  endfunction

  // mode 0: no idling, 1: occasional gaps, 2: random gap drawn before every word
  function automatic int draw_wait(input int mode);
    int w;
    w = 0;
    if (mode == 2 || (mode == 1 && $urandom_range(0, 3) == 0)) w = $urandom_range(0, 15);
    return w;
  endfunction

  function automatic logic [7:0] random_filler();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == CH_OPEN || b == CH_CLOSE || b == CH_CR || b == CH_LF);
    return b;
  endfunction

  task automatic send_byte(input logic [7:0] b, input chk_t chk, input word_t typed);
    int gap;
    int base;
    if (tx_left == 0) begin
      tx_mode = $urandom_range(0, 2);
      tx_left = $urandom_range(8, 24);
    end
    tx_left--;
    gap = draw_wait(tx_mode);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    rx_taken++;
    base = pending_words.size();
    absorb_rx_byte(b);
    // typed rows replace what the predictor queued, state still follows
    if (chk != CHK_PREDICT) begin
      while (pending_words.size() > base) void'(pending_words.pop_back());
      if (chk == CHK_ONE) pending_words.push_back(typed);
    end
  endtask

  task automatic send_word(input logic [7:0] b);
    send_byte(b, CHK_PREDICT, NO_WORD);
  endtask

  // '[' + n filler bytes + tail
  task automatic send_bracketed(input int n, input logic [7:0] tail);
    send_word(CH_OPEN);
    repeat (n) send_word(random_filler());
    send_word(tail);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    // a frame that releases nothing may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_delivery(input logic v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we     <= 1'b0;
    deliver_on = v;
  endtask

  task automatic play_random_sequence();
    int   kind;
    int   pos;
    logic [7:0] c;
    kind = $urandom_range(0, 9);
    if (kind <= 4) begin
      send_bracketed(($urandom_range(0, 7) == 0) ? $urandom_range(0, 61)
                                                 : $urandom_range(0, 6), CH_CLOSE);
    end else if (kind <= 6) begin
      // exact ping, or ping with one inner letter swapped
      pos = (kind == 5) ? -1 : $urandom_range(1, 4);
      for (int k = 0; k < 6; k++) begin
        c = (k == pos) ? random_filler() : PING_TEXT[8*(5-k) +: 8];
        send_word(c);
      end
    end else if (kind == 7) begin
      case ($urandom_range(0, 2))
        0:       c = CH_CR;
        1:       c = CH_LF;
        default: c = CH_OPEN;
      endcase
      send_bracketed($urandom_range(0, 5), c);
    end else begin
      repeat ($urandom_range(1, 4)) send_word(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic report_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t mismatch %s: expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // output checker
  always @(posedge clk) begin
    word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_words.size() == 0) begin
        $display("%0t unexpected word: expected none actual data %0h user %0b last %0b",
                 $time, out_tdata, out_tuser, out_tlast);
        errors++;
      end else begin
        want = pending_words.pop_front();
        report_field("frame_byte", want.data, out_tdata);
        report_field("byte_valid", want.valid, out_tuser[0]);
        report_field("frame_last", want.last, out_tlast);
        report_field("pong_request", want.pong, out_tuser[1]);
      end
    end
  end

  // receiver with random back-pressure
  initial begin
    int stall;
    int mode;
    int left;
    mode = 0;
    left = 0;
    out_tready = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (left == 0) begin
        mode = $urandom_range(0, 2);
        left = $urandom_range(8, 24);
      end
      left--;
      stall = draw_wait(mode);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin
    #20000000;
    $display("[bracket_frame_extractor_with_ping_core] ERROR");
    $finish;
  end

  initial begin
    int phase;
    int start;
    int phase_start;
    clk        = 1'b0;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_wdata  = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    frame_len  = 0;
    deliver_on = 1'b0;
    errors     = 0;
    rx_taken   = 0;
    tx_mode    = 0;
    tx_left    = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DIR_ROWS; r++) begin
      if (directed_rows[r].act != CFG_KEEP) set_delivery(directed_rows[r].act == CFG_ON);
      send_byte(directed_rows[r].rx, directed_rows[r].chk, directed_rows[r].typed);
    end

    start = rx_taken;
    phase = 0;
    while (rx_taken - start < RANDOM_WORDS) begin
      set_delivery(phase % 3 != 1);
      // longest frame once, and one overflow whose tail byte is dropped
      if (phase == 0) send_bracketed(FRAME_BYTES - 3, CH_CLOSE);
      if (phase == 2) begin
        case ($urandom_range(0, 2))
          0:       send_bracketed(FRAME_BYTES - 2, CH_OPEN);
          1:       send_bracketed(FRAME_BYTES - 2, CH_CLOSE);
          default: send_bracketed(FRAME_BYTES - 2, 8'($urandom_range(0, 255)));
        endcase
        send_word(CH_CLOSE);
      end
      phase_start = rx_taken;
      while (rx_taken - phase_start < PHASE_WORDS) begin
        play_random_sequence();
        if ($urandom_range(0, 9) == 0) drain();
      end
      phase++;
    end

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("[bracket_frame_extractor_with_ping_core] OK");
    end else begin
      $display("[bracket_frame_extractor_with_ping_core] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
